// File: src/router_adjacency_table_top_assert.svh
// Assertion macros for the router adjacency table.
`ifndef ROUTER_ADJACENCY_TABLE_TOP_ASSERT_SVH
`define ROUTER_ADJACENCY_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adjacency table check failed");
`define RAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adjacency table check failed");
`else
`define RAT_ASSERT_IMP(lbl, ante, cons)
`define RAT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/rat_pkg.sv
// Types and constants of the router adjacency table.
`default_nettype none
package rat_pkg;
  localparam int CIRCUIT_SLOTS = 4;
  localparam int ROUTER_SLOTS  = 16;
  localparam int ENDNODE_SLOTS = 32;
  localparam int TOTAL_SLOTS   = CIRCUIT_SLOTS + ROUTER_SLOTS + ENDNODE_SLOTS + 1;
  localparam int SLOT_W        = $clog2(TOTAL_SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t ROUTER_BASE  = slot_t'(CIRCUIT_SLOTS);
  localparam slot_t SPARE_SLOT   = slot_t'(CIRCUIT_SLOTS + ROUTER_SLOTS);
  localparam slot_t ENDNODE_BASE = slot_t'(CIRCUIT_SLOTS + ROUTER_SLOTS + 1);
  localparam slot_t LAST_SLOT    = slot_t'(TOTAL_SLOTS - 1);

  typedef enum logic [1:0] {
    REQ_ROUTER  = 2'd0,
    REQ_ENDNODE = 2'd1,
    REQ_PURGE   = 2'd2,
    REQ_STOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_UNUSED = 2'd0,
    KIND_L1     = 2'd1,
    KIND_L2     = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EV, S_DECIDE, S_XRD, S_XEV, S_EVICT, S_FINAL, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] node_address;
    logic [3:0]  circuit_id;
    logic        router_level;
    logic [15:0] hello_seconds;
    logic [6:0]  router_priority;
    logic        lists_this_node;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot_number;
    logic [15:0] peer_address;
    logic [3:0]  peer_circuit;
    logic        went_up;
    logic        last_event;
  } out_item_t;

  typedef struct packed {
    logic [15:0] address;
    logic [3:0]  circuit;
    logic [15:0] hello;
    logic [6:0]  prio;
    logic [31:0] heard;
  } entry_t;
endpackage
`default_nettype wire

// File: src/router_adjacency_table_top.sv
// Router adjacency table: top level with entry memory and sequencer.
`default_nettype none
`include "router_adjacency_table_top_assert.svh"
// Each item walks the 53-slot entry memory slot by slot, reading each slot
// and then evaluating it; a router hello that overflows the router region
// adds a second pass over the 17 router slots. Output stalls can hold the
// walk at an event. The entry memory has one read and one write port; kind
// and up bits live in flip-flops and clear at reset. in_stall is high while
// an item is in work.
module router_adjacency_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rat_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rat_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import rat_pkg::*;

  entry_t    mem [TOTAL_SLOTS];
  entry_t    rd_data_r;
  logic      rd_en;
  logic      wr_en;
  entry_t    wr_data;

  kind_t     kind_r [TOTAL_SLOTS];
  logic      up_r   [TOTAL_SLOTS];

  state_t    state_r, state_nxt;
  slot_t     idx_r, idx_nxt;
  in_item_t  req_r;
  logic [3:0] mult_r;
  logic      found_r, found_nxt;
  slot_t     fslot_r, fslot_nxt;
  entry_t    cap_r, cap_nxt;
  logic      free_r, free_nxt;
  slot_t     frslot_r, frslot_nxt;
  logic      new_r, new_nxt;
  slot_t     e_r, e_nxt;
  logic      sel_valid_r, sel_valid_nxt;
  slot_t     sel_r, sel_nxt;
  logic [6:0]  sel_prio_r, sel_prio_nxt;
  logic [15:0] sel_addr_r, sel_addr_nxt;
  logic [3:0]  sel_circ_r, sel_circ_nxt;
  logic      pend_valid_r, pend_valid_nxt;
  out_item_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic      kind_we;
  slot_t     kind_wslot;
  kind_t     kind_wval;
  logic      up_we;
  slot_t     up_wslot;
  logic      up_wval;

  logic      in_xfer;
  logic      out_free;
  logic      ev_req, ev_take, hold;
  out_item_t ev_item;
  logic      is_router_req;
  kind_t     new_kind;

  logic      match, in_region;
  logic [31:0] elapsed;
  logic [19:0] limit;
  logic [6:0]  x_prio;
  logic [15:0] x_addr;
  logic      cand;
  logic      cur_up;
  logic [3:0]  circ_w;
  logic [6:0]  prio_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign is_router_req = (req_r.req_type == REQ_ROUTER);
  assign new_kind = !is_router_req ? KIND_END : (req_r.router_level ? KIND_L2 : KIND_L1);

  assign match   = (kind_r[idx_r] != KIND_UNUSED) && (rd_data_r.address == req_r.node_address);
  assign in_region = is_router_req ? (idx_r >= ROUTER_BASE && idx_r <= SPARE_SLOT)
                                   : (idx_r >= ENDNODE_BASE);
  assign elapsed = req_r.now_seconds - rd_data_r.heard;
  assign limit   = 20'(mult_r) * 20'(rd_data_r.hello);

  // the newcomer sits in the spare slot but is not yet in memory
  assign x_prio = (idx_r == SPARE_SLOT) ? req_r.router_priority : rd_data_r.prio;
  assign x_addr = (idx_r == SPARE_SLOT) ? req_r.node_address : rd_data_r.address;
  assign cand   = !sel_valid_r || (x_prio < sel_prio_r) ||
                  ((x_prio == sel_prio_r) && (x_addr < sel_addr_r));

  assign cur_up = new_r ? 1'b0 : up_r[e_r];
  assign circ_w = new_r ? req_r.circuit_id : cap_r.circuit;
  assign prio_w = (is_router_req || new_r) ? req_r.router_priority : cap_r.prio;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    fslot_nxt      = fslot_r;
    cap_nxt        = cap_r;
    free_nxt       = free_r;
    frslot_nxt     = frslot_r;
    new_nxt        = new_r;
    e_nxt          = e_r;
    sel_valid_nxt  = sel_valid_r;
    sel_nxt        = sel_r;
    sel_prio_nxt   = sel_prio_r;
    sel_addr_nxt   = sel_addr_r;
    sel_circ_nxt   = sel_circ_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = '{address: req_r.node_address, circuit: circ_w,
                       hello: req_r.hello_seconds, prio: prio_w,
                       heard: req_r.now_seconds};
    kind_we        = 1'b0;
    kind_wslot     = idx_r;
    kind_wval      = KIND_UNUSED;
    up_we          = 1'b0;
    up_wslot       = idx_r;
    up_wval        = 1'b0;
    ev_req         = 1'b0;
    ev_item        = '{slot_number: 6'(idx_r) + 6'd1, peer_address: rd_data_r.address,
                       peer_circuit: rd_data_r.circuit, went_up: 1'b0, last_event: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        case (req_r.req_type)
          REQ_PURGE: begin
            if (kind_r[idx_r] != KIND_UNUSED && elapsed > {12'd0, limit}) begin
              ev_req = up_r[idx_r];
            end
          end
          REQ_STOP: begin
            ev_req = (kind_r[idx_r] != KIND_UNUSED);
          end
          default: begin
            if (match && !found_r) begin
              found_nxt = 1'b1;
              fslot_nxt = idx_r;
              cap_nxt   = rd_data_r;
            end
            if (kind_r[idx_r] == KIND_UNUSED && in_region && !free_r) begin
              free_nxt   = 1'b1;
              frslot_nxt = idx_r;
            end
          end
        endcase
        if (!hold) begin
          // delete timed-out or stopped entries
          if ((req_r.req_type == REQ_STOP && kind_r[idx_r] != KIND_UNUSED) ||
              (req_r.req_type == REQ_PURGE && kind_r[idx_r] != KIND_UNUSED &&
               elapsed > {12'd0, limit})) begin
            kind_we = 1'b1;
            up_we   = 1'b1;
          end
          if (idx_r == LAST_SLOT) begin
            state_nxt = (req_r.req_type == REQ_PURGE || req_r.req_type == REQ_STOP)
                        ? S_FLUSH : S_DECIDE;
          end else begin
            idx_nxt   = idx_r + slot_t'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_DECIDE: begin
        if (found_r) begin
          e_nxt     = fslot_r;
          new_nxt   = 1'b0;
          state_nxt = S_FINAL;
        end else if (free_r) begin
          e_nxt   = frslot_r;
          new_nxt = 1'b1;
          if (is_router_req && frslot_r == SPARE_SLOT) begin
            idx_nxt       = ROUTER_BASE;
            sel_valid_nxt = 1'b0;
            state_nxt     = S_XRD;
          end else begin
            state_nxt = S_FINAL;
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_XRD: begin
        rd_en     = 1'b1;
        state_nxt = S_XEV;
      end
      S_XEV: begin
        if (cand) begin
          sel_valid_nxt = 1'b1;
          sel_nxt       = idx_r;
          sel_prio_nxt  = x_prio;
          sel_addr_nxt  = x_addr;
          sel_circ_nxt  = rd_data_r.circuit;
        end
        if (idx_r == SPARE_SLOT) begin
          state_nxt = S_EVICT;
        end else begin
          idx_nxt   = idx_r + slot_t'(1);
          state_nxt = S_XRD;
        end
      end
      S_EVICT: begin
        if (sel_r == SPARE_SLOT) begin
          // the newcomer is the weakest: drop it
          state_nxt = S_FLUSH;
        end else begin
          ev_req  = up_r[sel_r];
          ev_item = '{slot_number: 6'(sel_r) + 6'd1, peer_address: sel_addr_r,
                      peer_circuit: sel_circ_r, went_up: 1'b0, last_event: 1'b0};
          if (!hold) begin
            kind_we    = 1'b1;
            kind_wslot = sel_r;
            kind_wval  = new_kind;
            up_we      = 1'b1;
            up_wslot   = sel_r;
            e_nxt      = sel_r;
            state_nxt  = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        ev_item = '{slot_number: 6'(e_r) + 6'd1, peer_address: req_r.node_address,
                    peer_circuit: circ_w, went_up: 1'b1, last_event: 1'b0};
        if (is_router_req) begin
          ev_req          = (cur_up != req_r.lists_this_node);
          ev_item.went_up = req_r.lists_this_node;
          up_wval         = req_r.lists_this_node;
        end else begin
          ev_req  = !cur_up;
          up_wval = 1'b1;
        end
        if (!hold) begin
          wr_en      = 1'b1;
          up_we      = 1'b1;
          up_wslot   = e_r;
          kind_we    = new_r;
          kind_wslot = e_r;
          kind_wval  = new_kind;
          state_nxt  = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // events pass through a one-deep pending slot so the final one gets its flag
  assign ev_take = ev_req && (!pend_valid_r || out_free);
  assign hold    = ev_req && !ev_take;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    if (ev_take) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = ev_item;
    end else if (state_r == S_FLUSH && pend_valid_r && out_free) begin
      out_valid_nxt       = 1'b1;
      out_nxt             = pend_r;
      out_nxt.last_event  = 1'b1;
      pend_valid_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[idx_r];
    end
    if (wr_en) begin
      mem[e_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mult_r       <= 4'd3;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        kind_r[i] <= KIND_UNUSED;
        up_r[i]   <= 1'b0;
      end
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mult_r <= cfg_data;
      end
      if (kind_we) begin
        kind_r[kind_wslot] <= kind_wval;
      end
      if (up_we) begin
        up_r[up_wslot] <= up_wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    fslot_r     <= fslot_nxt;
    cap_r       <= cap_nxt;
    free_r      <= free_nxt;
    frslot_r    <= frslot_nxt;
    new_r       <= new_nxt;
    e_r         <= e_nxt;
    sel_valid_r <= sel_valid_nxt;
    sel_r       <= sel_nxt;
    sel_prio_r  <= sel_prio_nxt;
    sel_addr_r  <= sel_addr_nxt;
    sel_circ_r  <= sel_circ_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  `RAT_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r)
  `RAT_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall)
  `RAT_ASSERT_IMP(a_spare_empty, state_r == S_IDLE, kind_r[SPARE_SLOT] == KIND_UNUSED)

endmodule
`default_nettype wire

// File: sim/router_adjacency_table_top_tb.sv
// Testbench for the router adjacency table: hello, purge and stop traffic checked per event.
`timescale 1ns / 1ps
module router_adjacency_table_top_tb;
  import rat_pkg::*;

  localparam int NSLOT = TOTAL_SLOTS;
  localparam int RBASE = CIRCUIT_SLOTS;
  localparam int SPARE = CIRCUIT_SLOTS + ROUTER_SLOTS;
  localparam int EBASE = CIRCUIT_SLOTS + ROUTER_SLOTS + 1;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [3:0] cfg_data;

  router_adjacency_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // adjacency table shadow
  kind_t       tbl_kind [NSLOT];
  logic [15:0] tbl_addr [NSLOT];
  logic [3:0]  tbl_circ [NSLOT];
  logic        tbl_up [NSLOT];
  logic [15:0] tbl_hello [NSLOT];
  logic [6:0]  tbl_prio [NSLOT];
  logic [31:0] tbl_heard [NSLOT];
  int          n_routers, n_endnodes;
  logic [3:0]  timeout_mult;

  in_item_t  pending_items[$];
  out_item_t expected_events[$];
  out_item_t item_events[$];

  int  mismatches, events_seen, items_sent;
  bit  timed_out, stim_done;
  longint cycle_count;
  int  hold_off;
  bit  long_hold_req;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_rtr(int i);
    return tbl_kind[i] == KIND_L1 || tbl_kind[i] == KIND_L2;
  endfunction

  function automatic void note_event(int i, logic up);
    out_item_t ev;
    ev.slot_number = 6'(i + 1);
    ev.peer_address = tbl_addr[i];
    ev.peer_circuit = tbl_circ[i];
    ev.went_up = up;
    ev.last_event = 1'b0;
    item_events.push_back(ev);
  endfunction

  function automatic void wipe_slot(int i);
    tbl_kind[i] = KIND_UNUSED;
    tbl_addr[i] = '0; tbl_circ[i] = '0; tbl_up[i] = 0;
    tbl_hello[i] = '0; tbl_prio[i] = '0; tbl_heard[i] = '0;
  endfunction

  function automatic void drop_slot(int i);
    if (is_rtr(i)) begin
      if (n_routers > 0) n_routers--;
    end else if (tbl_kind[i] == KIND_END) begin
      if (n_endnodes > 0) n_endnodes--;
    end
    wipe_slot(i);
  endfunction

  function automatic int evict_lowest(int added);
    int sel;
    sel = -1;
    for (int i = RBASE; i <= SPARE; i++) begin
      if (!is_rtr(i)) continue;
      if (sel < 0 || tbl_prio[i] < tbl_prio[sel] ||
          (tbl_prio[i] == tbl_prio[sel] && tbl_addr[i] < tbl_addr[sel]))
        sel = i;
    end
    if (sel < 0) return added;
    if (tbl_up[sel]) note_event(sel, 1'b0);
    drop_slot(sel);
    if (sel == added) return -1;
    if (sel != SPARE && tbl_kind[SPARE] != KIND_UNUSED) begin
      tbl_kind[sel] = tbl_kind[SPARE]; tbl_addr[sel] = tbl_addr[SPARE];
      tbl_circ[sel] = tbl_circ[SPARE]; tbl_up[sel] = tbl_up[SPARE];
      tbl_hello[sel] = tbl_hello[SPARE]; tbl_prio[sel] = tbl_prio[SPARE];
      tbl_heard[sel] = tbl_heard[SPARE];
      wipe_slot(SPARE);
      if (added == SPARE) added = sel;
    end
    return added;
  endfunction

  // advance the shadow table by one item and queue its events
  function automatic void predict_adjacency(in_item_t it);
    int e, from, cnt;
    logic [31:0] elapsed, lim;
    item_events.delete();
    if (it.req_type == REQ_ROUTER || it.req_type == REQ_ENDNODE) begin
      e = -1;
      for (int i = 0; i < NSLOT; i++)
        if (e < 0 && tbl_kind[i] != KIND_UNUSED && tbl_addr[i] == it.node_address) e = i;
      if (e < 0) begin
        from = (it.req_type == REQ_ROUTER) ? RBASE : EBASE;
        cnt = (it.req_type == REQ_ROUTER) ? ROUTER_SLOTS + 1 : ENDNODE_SLOTS;
        for (int i = from; i < from + cnt && i < NSLOT; i++)
          if (e < 0 && tbl_kind[i] == KIND_UNUSED) e = i;
        if (e >= 0) begin
          tbl_kind[e] = (it.req_type == REQ_ENDNODE) ? KIND_END :
                        (it.router_level ? KIND_L2 : KIND_L1);
          tbl_addr[e] = it.node_address;
          tbl_circ[e] = it.circuit_id;
          tbl_up[e] = 0;
          tbl_hello[e] = it.hello_seconds;
          tbl_prio[e] = it.router_priority;
          if (it.req_type == REQ_ROUTER) begin
            n_routers++;
            if (n_routers > ROUTER_SLOTS) e = evict_lowest(e);
          end else n_endnodes++;
        end
      end
      if (e >= 0) begin
        tbl_heard[e] = it.now_seconds;
        tbl_hello[e] = it.hello_seconds;
        if (it.req_type == REQ_ROUTER) begin
          tbl_prio[e] = it.router_priority;
          if (!tbl_up[e] && it.lists_this_node) begin
            tbl_up[e] = 1; note_event(e, 1'b1);
          end else if (tbl_up[e] && !it.lists_this_node) begin
            tbl_up[e] = 0; note_event(e, 1'b0);
          end
        end else if (!tbl_up[e]) begin
          tbl_up[e] = 1; note_event(e, 1'b1);
        end
      end
    end else if (it.req_type == REQ_PURGE) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_kind[i] == KIND_UNUSED) continue;
        elapsed = it.now_seconds - tbl_heard[i];
        lim = 32'(timeout_mult) * 32'(tbl_hello[i]);
        if (elapsed > lim) begin
          if (tbl_up[i]) note_event(i, 1'b0);
          drop_slot(i);
        end
      end
    end else begin
      for (int i = 0; i < NSLOT; i++) begin
        if (tbl_kind[i] == KIND_UNUSED) continue;
        tbl_up[i] = 0;
        note_event(i, 1'b0);
        drop_slot(i);
      end
    end
    if (item_events.size() > 0) item_events[item_events.size() - 1].last_event = 1'b1;
    foreach (item_events[k]) expected_events.push_back(item_events[k]);
  endfunction

  // driver: bursts of transfers with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_adjacency(in_data);
        items_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end else burst_left <= burst_left - 1;
        end else in_valid <= 0;
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_phase <= 0;
      hold_off <= 0;
    end else if (long_hold_req && hold_off == 0) begin
      hold_off <= 3000;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= (hold_off > 1);
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event %p", out_data);
      end else begin
        want = expected_events.pop_front();
        if (out_data.slot_number !== want.slot_number ||
            out_data.peer_address !== want.peer_address ||
            out_data.peer_circuit !== want.peer_circuit ||
            out_data.went_up !== want.went_up ||
            out_data.last_event !== want.last_event) begin
          mismatches++;
          if (mismatches <= 10) $display("event mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("timeout after %0d cycles", cycle_count);
      $display("router_adjacency_table_top regression: fail");
      $finish;
    end
  end

  function automatic in_item_t mk_item(req_e r, logic [15:0] a, logic [3:0] c, logic lvl,
                                       logic [15:0] h, logic [6:0] p, logic lst,
                                       logic [31:0] now);
    in_item_t it;
    it.req_type = r; it.node_address = a; it.circuit_id = c; it.router_level = lvl;
    it.hello_seconds = h; it.router_priority = p; it.lists_this_node = lst;
    it.now_seconds = now;
    return it;
  endfunction

  function automatic in_item_t rand_item(ref logic [31:0] clock_s);
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    clock_s += $urandom_range(0, 40);
    it = mk_item(REQ_ROUTER, 16'($urandom_range(0, 40)), 4'($urandom), 1'($urandom),
                 16'($urandom_range(1, 20)), 7'($urandom), 1'($urandom), clock_s);
    if (pick < 3) it.node_address = 16'($urandom);
    if (pick < 6) it.hello_seconds = 16'($urandom);
    if ($urandom_range(0, 9) == 0) it.now_seconds = $urandom;
    if (pick < 50) it.req_type = REQ_ROUTER;
    else if (pick < 85) it.req_type = REQ_ENDNODE;
    else if (pick < 96) it.req_type = REQ_PURGE;
    else it.req_type = REQ_STOP;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || in_stall || expected_events.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mult(logic [3:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    timeout_mult = v;
  endtask

  initial begin
    logic [31:0] clk_s;
    logic [3:0] mults [4];
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    long_hold_req = 0;
    timeout_mult = 4'd3;
    n_routers = 0;
    n_endnodes = 0;
    for (int i = 0; i < NSLOT; i++) wipe_slot(i);
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, every request, eviction, other-kind refresh
    clk_s = 32'd1000;
    pending_items.push_back(mk_item(REQ_ROUTER, 16'hFFFF, 4'hF, 1, 16'hFFFF, 7'h7F, 1, 32'hFFFF_FFFF));
    pending_items.push_back(mk_item(REQ_ROUTER, 16'h0000, 4'h0, 0, 16'h0000, 7'h00, 1, 32'h0));
    pending_items.push_back(mk_item(REQ_ENDNODE, 16'h0000, 4'h3, 0, 16'd5, 7'h11, 0, 32'd10));
    pending_items.push_back(mk_item(REQ_ENDNODE, 16'h1234, 4'h5, 1, 16'd5, 7'h22, 1, 32'd10));
    pending_items.push_back(mk_item(REQ_ROUTER, 16'h1234, 4'h9, 1, 16'd7, 7'h40, 1, 32'd12));
    pending_items.push_back(mk_item(REQ_ROUTER, 16'hFFFF, 4'hF, 1, 16'd9, 7'h7F, 0, 32'd12));
    for (int i = 0; i < 17; i++)
      pending_items.push_back(mk_item(REQ_ROUTER, 16'(16'h0100 + i), 4'(i), 1'(i), 16'd10,
                                      7'(i == 16 ? 0 : 10 + i), 1'(i % 2), 32'd20));
    pending_items.push_back(mk_item(REQ_PURGE, 16'h0, 4'h0, 0, 16'h0, 7'h0, 0, 32'd40));
    pending_items.push_back(mk_item(REQ_STOP, 16'hAAAA, 4'h5, 1, 16'h5555, 7'h2A, 1, 32'd50));
    wait_drained();

    mults[0] = 4'd15; mults[1] = 4'd1; mults[2] = 4'd0; mults[3] = 4'd7;
    for (int ph = 0; ph < 4; ph++) begin
      write_mult(mults[ph]);
      // fill the endnode region past full in the first phase
      if (ph == 0)
        for (int i = 0; i < 34; i++)
          pending_items.push_back(mk_item(REQ_ENDNODE, 16'(16'h4000 + i), 4'(i), 0, 16'd3,
                                          7'd0, 0, clk_s));
      for (int i = 0; i < 45; i++) pending_items.push_back(rand_item(clk_s));
      if (ph == 1) begin
        // hold the request until the receiver has started its hold-off
        long_hold_req = 1;
        wait (hold_off != 0);
        long_hold_req = 0;
      end
      wait_drained();
    end

    $display("covered %0d items and %0d events over four timeout settings,", items_sent,
             events_seen);
    $display("including eviction, endnode overflow, purge, stop and a long output hold-off");
    if (mismatches == 0 && expected_events.size() == 0)
      $display("router_adjacency_table_top regression: pass");
    else
      $display("router_adjacency_table_top regression: fail");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/rat_pkg.sv
src/router_adjacency_table_top.sv
sim/router_adjacency_table_top_tb.sv
